// File: src/assert_macros.svh
// assertion macros used by the top level of the frame receiver
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AST_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define AST_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/swfr_pkg.sv
// types and constants of the sync word frame receiver
// no dependencies
package swfr_pkg;

   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;

   // receive phases
   localparam logic [2:0] PH_SYNC0 = 3'd0;
   localparam logic [2:0] PH_SYNC1 = 3'd1;
   localparam logic [2:0] PH_SYNC2 = 3'd2;
   localparam logic [2:0] PH_SYNC3 = 3'd3;
   localparam logic [2:0] PH_LEN   = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_CHK   = 3'd6;
   localparam logic [2:0] PH_END   = 3'd7;

   // report status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_LEN_ERR = 2'd1;
   localparam logic [1:0] ST_CHK_ERR = 2'd2;
   localparam logic [1:0] ST_END_ERR = 2'd3;

   // result kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register indexes
   localparam logic [2:0] REG_SYNC_WORD      = 3'd0;
   localparam logic [2:0] REG_MIN_LENGTH     = 3'd1;
   localparam logic [2:0] REG_TRAILER_LENGTH = 3'd2;
   localparam logic [2:0] REG_END_BYTE       = 3'd3;
   localparam logic [2:0] REG_MAX_LENGTH     = 3'd4;

   typedef struct packed {
      logic [31:0] sync_word;
      logic [7:0]  min_length;
      logic [7:0]  trailer_length;
      logic [7:0]  end_byte;
      logic [6:0]  max_length;
   } cfg_type;

   // report command from front to back
   typedef struct packed {
      logic               drain;   // 1: report stored bytes, 0: one status item
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   // payload store write
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] addr;
      logic [7:0]         data;
   } wr_type;

endpackage

// File: src/swfr_front.sv
// front part: sync hunt, length check, data store, checksum and end byte
// depends on swfr_pkg
module swfr_front #(
   parameter int STORE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  swfr_pkg::cfg_type cfg,
   input  logic             push,
   output logic             full,
   input  logic [7:0]       rx_byte,
   input  logic             q_full,
   input  logic             drain_busy,
   output logic             cmd_push,
   output swfr_pkg::cmd_type cmd,
   output swfr_pkg::wr_type wr
);
   import swfr_pkg::*;

   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(STORE_DEPTH);

   logic [2:0]         phase_ff, phase_in;
   logic [7:0]         len_ff, len_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   logic [COUNT_W-1:0] eff_max;
   logic [7:0]         bound;
   logic [7:0]         sync_sel;
   logic               accept;

   assign eff_max = (cfg.max_length < DEPTH_C) ? cfg.max_length : DEPTH_C;
   assign bound   = (len_ff > cfg.trailer_length) ? (len_ff - cfg.trailer_length) : 8'd0;

   // data bytes wait while an earlier frame is still read out of the store
   assign full   = q_full | ((phase_ff == PH_DATA) & drain_busy);
   assign accept = push & ~full;

   always_comb begin
      case (phase_ff)
         PH_SYNC1: sync_sel = cfg.sync_word[15:8];
         PH_SYNC2: sync_sel = cfg.sync_word[23:16];
         PH_SYNC3: sync_sel = cfg.sync_word[31:24];
         default:  sync_sel = cfg.sync_word[7:0];
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      cmd_push = 1'b0;
      cmd      = '{drain: 1'b0, status: ST_OK, count: '0};
      wr       = '{en: 1'b0, addr: count_ff[INDEX_W-1:0], data: rx_byte};
      if (accept) begin
         case (phase_ff)
            PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
               if (rx_byte == sync_sel) begin
                  phase_in = phase_ff + 3'd1;
                  if (phase_ff == PH_SYNC3) begin
                     count_in = '0;
                  end
               end else begin
                  phase_in = PH_SYNC0;
               end
            end
            PH_LEN: begin
               len_in = rx_byte;
               if ((rx_byte < cfg.min_length) || (rx_byte > {1'b0, eff_max})) begin
                  phase_in   = PH_SYNC0;
                  cmd_push   = 1'b1;
                  cmd.status = ST_LEN_ERR;
               end else begin
                  sum_in   = rx_byte;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               if (count_ff < eff_max) begin
                  wr.en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               sum_in = sum_ff + rx_byte;
               if (bound <= {1'b0, count_in}) begin
                  phase_in = PH_CHK;
               end
            end
            PH_CHK: begin
               if (sum_ff == rx_byte) begin
                  phase_in = PH_END;
               end else begin
                  phase_in   = PH_SYNC0;
                  cmd_push   = 1'b1;
                  cmd.status = ST_CHK_ERR;
               end
            end
            PH_END: begin
               phase_in = PH_SYNC0;
               cmd_push = 1'b1;
               if (rx_byte != cfg.end_byte) begin
                  cmd.status = ST_END_ERR;
               end else if (count_ff != '0) begin
                  cmd.drain = 1'b1;
                  cmd.count = count_ff;
               end
            end
            default: begin
               phase_in = (rx_byte == sync_sel) ? PH_SYNC1 : PH_SYNC0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC0;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// File: src/swfr_cmd_fifo.sv
// two-entry queue of report commands between front and back
// depends on swfr_pkg
module swfr_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  swfr_pkg::cmd_type wr_cmd,
   output logic              q_full,
   input  logic              rd_en,
   output logic              q_empty,
   output swfr_pkg::cmd_type rd_cmd
);
   import swfr_pkg::*;

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_wr, do_rd;

   assign q_full  = (fill_ff == 2'd2);
   assign q_empty = (fill_ff == 2'd0);
   assign rd_cmd  = slot_ff[rptr_ff];
   assign do_wr   = wr_en & ~q_full;
   assign do_rd   = rd_en & ~q_empty;

   always_comb begin
      wptr_in = wptr_ff ^ do_wr;
      rptr_in = rptr_ff ^ do_rd;
      fill_in = fill_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// File: src/swfr_back.sv
// back part: payload store and frame report sequencer with output register
// depends on swfr_pkg
module swfr_back #(
   parameter int STORE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  swfr_pkg::wr_type  wr,
   input  logic              q_empty,
   input  swfr_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              drain_busy,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_kind,
   output logic [7:0]        rsp_byte_value,
   output logic [5:0]        rsp_byte_index,
   output logic [1:0]        rsp_status,
   output logic              rsp_last
);
   import swfr_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_LOAD = 2'd2;

   logic [7:0]         store_mem [STORE_DEPTH];
   logic [7:0]         rd_data_ff;
   logic [1:0]         state_ff, state_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic               kind_ff, kind_in;
   logic [7:0]         value_ff, value_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [1:0]         status_ff, status_in;
   logic               last_ff, last_in;
   logic               out_free;
   logic               at_last;

   assign out_free   = ~out_valid_ff | pop;
   assign at_last    = ({1'b0, idx_ff} + 1'b1) == cnt_ff;
   assign drain_busy = (state_ff != B_IDLE) | ~q_empty;

   assign empty          = ~out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_byte_value = value_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr[AW-1:0]] <= wr.data;
      end
      if (state_ff == B_READ) begin
         rd_data_ff <= store_mem[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff & ~pop;
      kind_in      = kind_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (q_cmd.drain) begin
                  q_pop    = 1'b1;
                  cnt_in   = q_cmd.count;
                  idx_in   = '0;
                  state_in = B_READ;
               end else if (out_free) begin
                  q_pop        = 1'b1;
                  out_valid_in = 1'b1;
                  kind_in      = KIND_STATUS;
                  value_in     = '0;
                  index_in     = '0;
                  status_in    = q_cmd.status;
                  last_in      = 1'b1;
               end
            end
         end
         B_READ: begin
            state_in = B_LOAD;
         end
         B_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               kind_in      = KIND_BYTE;
               value_in     = rd_data_ff;
               index_in     = idx_ff;
               status_in    = ST_OK;
               last_in      = at_last;
               idx_in       = idx_ff + 1'b1;
               state_in     = at_last ? B_IDLE : B_READ;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

endmodule

// File: src/sync_word_frame_receiver.sv
// top level of the sync word frame receiver: registers, front, queue, back
// depends on swfr_pkg, swfr_front, swfr_cmd_fifo, swfr_back, assert_macros.svh
//
//   channel   handshake              payload
//   input     push / full            req_rx_byte
//   result    empty / pop            rsp_kind, rsp_byte_value, rsp_byte_index,
//                                    rsp_status, rsp_last
//   config    valid / ready          csr_index, csr_data
//
// one byte is taken per cycle unless full; no result for sync, data or in-range length bytes.
// a frame report is either one status item or the stored bytes; each stored byte passes
// through the store read (B_READ) and then the output register load (B_LOAD).
// data bytes of a new frame stall (full high) until the previous report has read the store.
// full is also high while the two-entry command queue is full.
// synchronous reset clears phase, front counters, queue and output valid; store is not cleared.
module sync_word_frame_receiver #(
   parameter int STORE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [5:0]  rsp_byte_index,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        valid,
   output logic        ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import swfr_pkg::*;

`include "assert_macros.svh"

   cfg_type cfg_ff, cfg_in;
   cmd_type front_cmd, q_cmd;
   wr_type  wr;
   logic    cmd_push, q_full, q_empty, q_pop, drain_busy;

   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         case (csr_index)
            REG_SYNC_WORD:      cfg_in.sync_word      = csr_data;
            REG_MIN_LENGTH:     cfg_in.min_length     = csr_data[7:0];
            REG_TRAILER_LENGTH: cfg_in.trailer_length = csr_data[7:0];
            REG_END_BYTE:       cfg_in.end_byte       = csr_data[7:0];
            REG_MAX_LENGTH:     cfg_in.max_length     = csr_data[6:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sync_word: 32'd0, min_length: 8'd3, trailer_length: 8'd2,
                     end_byte: 8'd0, max_length: 7'd50};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swfr_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .full       (full),
      .rx_byte    (req_rx_byte),
      .q_full     (q_full),
      .drain_busy (drain_busy),
      .cmd_push   (cmd_push),
      .cmd        (front_cmd),
      .wr         (wr)
   );

   swfr_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_cmd  (front_cmd),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_cmd  (q_cmd)
   );

   swfr_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .wr             (wr),
      .q_empty        (q_empty),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .drain_busy     (drain_busy),
      .empty          (empty),
      .pop            (pop),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   // the store is never written while a report may still read it
   `AST_SAME(a_store_guard, clock, reset, wr.en, !drain_busy)
   // a command is never offered to a full queue
   `AST_SAME(a_queue_room, clock, reset, cmd_push, !q_full)
   // status items stand alone and carry no byte
   `AST_SAME(a_status_item, clock, reset, !empty && rsp_kind,
             rsp_last && (rsp_byte_value == 8'd0) && (rsp_byte_index == 6'd0))
   // a status command taken from the queue is on the outputs next cycle
   `AST_NEXT(a_report_done, clock, reset, q_pop && !q_cmd.drain, !empty)

endmodule
